>>> rtl/sts_pkg.sv
// shared types, character codes and helper functions for the signature token scanner
`timescale 1ns / 1ps

package sts_pkg;

  // number width and derived widths
  localparam int VALUE_BITS = 32;
  localparam int ACC_W      = VALUE_BITS;
  localparam int SPAN_W     = VALUE_BITS - 1;
  localparam int PROD_W     = VALUE_BITS + 4;
  localparam int EXT_W      = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  // port payload widths
  localparam int CH_W    = 8;
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 3;
  localparam int TDATA_W = 56;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_ESC   = 8'h21;

  // scanner phases
  typedef enum logic [2:0] {
    PH_TAG,
    PH_FIRST,
    PH_NUM,
    PH_SPAN,
    PH_ERR
  } phase_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    K_INT   = 3'd0,
    K_HDR   = 3'd1,
    K_SBYTE = 3'd2,
    K_END   = 3'd3,
    K_ERR   = 3'd4
  } kind_t;

  // one result item without its run marker
  typedef struct packed {
    kind_t            kind;
    logic [CH_W-1:0]  tag;
    logic [VAL_W-1:0] value;
    logic [CH_W-1:0]  span_byte;
    logic             span_done;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  function automatic logic is_int_tag(input logic [CH_W-1:0] c);
    return (c == CH_UNDER) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_span_tag(input logic [CH_W-1:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two's complement value of a magnitude and sign, cut to the port width
  function automatic logic [VAL_W-1:0] signed_val(input logic [ACC_W-1:0] acc,
                                                  input logic neg);
    logic [EXT_W-1:0] e;
    e = EXT_W'(acc);
    if (neg) begin
      e = EXT_W'(0) - e;
    end
    return e[VAL_W-1:0];
  endfunction

  function automatic res_t mk_res(input kind_t kind, input logic [CH_W-1:0] tag,
                                  input logic [VAL_W-1:0] value,
                                  input logic [CH_W-1:0] sb, input logic done);
    res_t r;
    r.kind      = kind;
    r.tag       = tag;
    r.value     = value;
    r.span_byte = sb;
    r.span_done = done;
    return r;
  endfunction

endpackage

>>> rtl/signature_token_scanner.sv
// top level of the signature token scanner: input register, scanner and result queue
`timescale 1ns / 1ps

// Scans a signature one byte per request and emits integer tokens, span
// headers, span bytes, an end token or one sticky error. A byte is taken
// into an input register, worked on by the scanner once the queue has room,
// and its results land in a two-entry queue, so the first result of a byte
// passes the input register and a queue entry before it appears. The input
// takes one byte per cycle as long as the output is drained; the output port
// moves one result per cycle while out_tready is high, so a byte that causes
// two results (a number closing on the last byte, an integer followed by a
// bad tag, a token followed by the end or an error) holds the output longer
// and the queue absorbs it. out_tlast marks the final result caused by one
// input byte; out_tuser carries the result kind.
module signature_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] tag, [39:8] value, [47:40] span_byte,
                                  // [48] span_done, [55:49] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);

  logic                       in_valid_r, in_valid_nxt;
  logic [sts_pkg::CH_W-1:0]   in_ch_r;
  logic                       in_last_r;
  logic                       in_acc;
  logic                       advance;
  logic                       q_room;
  logic                       core_push;
  sts_pkg::bundle_t           core_bundle;
  sts_pkg::res_t              q_res;
  logic                       q_last;

  // input register
  always_comb begin
    advance      = in_valid_r && q_room;
    in_tready    = !in_valid_r || advance;
    in_acc       = in_tvalid && in_tready;
    in_valid_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_ch_r   <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // scanner
  sts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .ch     (in_ch_r),
    .last   (in_last_r),
    .push   (core_push),
    .bundle (core_bundle)
  );

  // result queue
  sts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_push),
    .push_data (core_bundle),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (q_res),
    .out_last  (q_last)
  );

  // output packing
  always_comb begin
    out_tdata = {7'd0, q_res.span_done, q_res.span_byte, q_res.value, q_res.tag};
    out_tuser = q_res.kind;
    out_tlast = q_last;
  end

`ifndef ASSERT_OFF
  // the scanner only produces results when the queue has space for them
  assert property (@(posedge clk) disable iff (!rst_n) core_push |-> q_room)
    else $error("result pushed into a full queue");

  // a stalled byte stays in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid_r && !advance) |=> in_valid_r)
    else $error("stalled input byte lost");

  // the second result of a byte follows the first
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_tvalid && !out_tlast) |=> out_tvalid)
    else $error("second result of a byte missing");
`endif

endmodule

>>> rtl/sts_core.sv
// token scanner state and per-byte step logic
`timescale 1ns / 1ps

module sts_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [sts_pkg::CH_W-1:0]  ch,
  input  logic                      last,
  output logic                      push,
  output sts_pkg::bundle_t          bundle
);

  sts_pkg::phase_t                   phase_r, phase_nxt;
  logic [sts_pkg::CH_W-1:0]          tag_r, tag_nxt;
  logic [sts_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                              neg_r, neg_nxt;
  logic                              seen_r, seen_nxt;
  logic                              ovf_r, ovf_nxt;
  logic [sts_pkg::SPAN_W-1:0]        left_r, left_nxt;

  logic [sts_pkg::PROD_W-1:0]        prod;
  logic [sts_pkg::PROD_W-1:0]        lim;
  logic                              dig_big;
  logic                              dig_ovf;
  logic [sts_pkg::ACC_W-1:0]         dig_acc;
  logic [sts_pkg::SPAN_W-1:0]        span;
  logic                              at_end;
  logic [1:0]                        n;
  sts_pkg::res_t                     r0;
  sts_pkg::res_t                     r1;

  // next decimal digit: accum * 10 + d, checked against the signed range
  always_comb begin
    prod = (sts_pkg::PROD_W'(acc_r) << 3) + (sts_pkg::PROD_W'(acc_r) << 1)
         + sts_pkg::PROD_W'(ch[3:0]);
    lim  = {5'd0, {(sts_pkg::VALUE_BITS-1){1'b1}}} + sts_pkg::PROD_W'(neg_r);
    dig_big = prod > lim;
    dig_ovf = ovf_r || dig_big;
    dig_acc = dig_ovf ? acc_r : prod[sts_pkg::ACC_W-1:0];
  end

  // step logic: results and next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    left_nxt  = left_r;
    span      = '0;
    at_end    = 1'b0;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    if (step) begin
      case (phase_r)
        sts_pkg::PH_TAG: begin
          tag_nxt  = ch;
          acc_nxt  = '0;
          neg_nxt  = 1'b0;
          seen_nxt = 1'b0;
          ovf_nxt  = 1'b0;
          left_nxt = '0;
          if (!(sts_pkg::is_int_tag(ch) || sts_pkg::is_span_tag(ch)) || last) begin
            phase_nxt = sts_pkg::PH_ERR;
            r0 = sts_pkg::mk_res(sts_pkg::K_ERR, ch, '0, '0, 1'b0);
            n  = 2'd1;
          end else begin
            phase_nxt = sts_pkg::PH_FIRST;
          end
        end
        sts_pkg::PH_FIRST: begin
          if (sts_pkg::is_digit(ch)) begin
            seen_nxt  = 1'b1;
            ovf_nxt   = dig_ovf;
            acc_nxt   = dig_acc;
            phase_nxt = sts_pkg::PH_NUM;
            at_end    = last;
          end else if (ch == sts_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = sts_pkg::PH_NUM;
            at_end    = last;
          end else begin
            phase_nxt = sts_pkg::PH_ERR;
            r0 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
            n  = 2'd1;
          end
        end
        sts_pkg::PH_NUM: begin
          if (sts_pkg::is_digit(ch)) begin
            seen_nxt = 1'b1;
            ovf_nxt  = dig_ovf;
            acc_nxt  = dig_acc;
            at_end   = last;
          end else if (!seen_r || ovf_r) begin
            // missing number or overflow
            phase_nxt = sts_pkg::PH_ERR;
            r0 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
            n  = 2'd1;
          end else if (sts_pkg::is_int_tag(tag_r)) begin
            // integer ends at the next tag, which starts a new token
            r0 = sts_pkg::mk_res(sts_pkg::K_INT, tag_r,
                                 sts_pkg::signed_val(acc_r, neg_r), '0, 1'b0);
            n  = 2'd1;
            tag_nxt  = ch;
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            seen_nxt = 1'b0;
            ovf_nxt  = 1'b0;
            left_nxt = '0;
            if (!(sts_pkg::is_int_tag(ch) || sts_pkg::is_span_tag(ch)) || last) begin
              phase_nxt = sts_pkg::PH_ERR;
              r1 = sts_pkg::mk_res(sts_pkg::K_ERR, ch, '0, '0, 1'b0);
              n  = 2'd2;
            end else begin
              phase_nxt = sts_pkg::PH_FIRST;
            end
          end else if (neg_r || (acc_r == '0) || (ch != sts_pkg::CH_ESC)) begin
            // bad span length or missing escape byte
            phase_nxt = sts_pkg::PH_ERR;
            r0 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
            n  = 2'd1;
          end else begin
            // span header, escape byte dropped
            span     = acc_r[sts_pkg::SPAN_W-1:0] - sts_pkg::SPAN_W'(1);
            left_nxt = span;
            r0 = sts_pkg::mk_res(sts_pkg::K_HDR, tag_r,
                                 sts_pkg::VAL_W'(sts_pkg::EXT_W'(span)), '0,
                                 span == '0);
            n  = 2'd1;
            if (span == '0) begin
              phase_nxt = sts_pkg::PH_TAG;
              if (last) begin
                r1 = sts_pkg::mk_res(sts_pkg::K_END, '0, '0, '0, 1'b0);
                n  = 2'd2;
              end
            end else begin
              phase_nxt = sts_pkg::PH_SPAN;
              if (last) begin
                phase_nxt = sts_pkg::PH_ERR;
                r1 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
                n  = 2'd2;
              end
            end
          end
        end
        sts_pkg::PH_SPAN: begin
          span     = (left_r == '0) ? '0 : left_r - sts_pkg::SPAN_W'(1);
          left_nxt = span;
          r0 = sts_pkg::mk_res(sts_pkg::K_SBYTE, tag_r, '0, ch, span == '0);
          n  = 2'd1;
          if (span == '0) begin
            phase_nxt = sts_pkg::PH_TAG;
            if (last) begin
              r1 = sts_pkg::mk_res(sts_pkg::K_END, '0, '0, '0, 1'b0);
              n  = 2'd2;
            end
          end else if (last) begin
            phase_nxt = sts_pkg::PH_ERR;
            r1 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
            n  = 2'd2;
          end
        end
        default: begin
        end
      endcase

      // number closed by the end of the signature
      if (at_end) begin
        if (sts_pkg::is_int_tag(tag_r) && seen_nxt && !ovf_nxt) begin
          r0 = sts_pkg::mk_res(sts_pkg::K_INT, tag_r,
                               sts_pkg::signed_val(acc_nxt, neg_nxt), '0, 1'b0);
          r1 = sts_pkg::mk_res(sts_pkg::K_END, '0, '0, '0, 1'b0);
          n  = 2'd2;
          phase_nxt = sts_pkg::PH_TAG;
        end else begin
          r0 = sts_pkg::mk_res(sts_pkg::K_ERR, tag_r, '0, '0, 1'b0);
          n  = 2'd1;
          phase_nxt = sts_pkg::PH_ERR;
        end
      end

      // rearm after the last byte
      if (last) begin
        phase_nxt = sts_pkg::PH_TAG;
        tag_nxt   = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
        left_nxt  = '0;
      end
    end
  end

  // result bundle toward the queue
  always_comb begin
    push       = step && (n != 2'd0);
    bundle.two = (n == 2'd2);
    bundle.r0  = r0;
    bundle.r1  = r1;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sts_pkg::PH_TAG;
      tag_r   <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

>>> rtl/sts_outq.sv
// two-entry result queue that sends each byte's results one per cycle while out_ready is high
`timescale 1ns / 1ps

module sts_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sts_pkg::bundle_t push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output sts_pkg::res_t    out_res,
  output logic             out_last
);

  sts_pkg::bundle_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             sub_r, sub_nxt;
  sts_pkg::bundle_t head;
  logic             beat;
  logic             pop;

  // head entry and the result it shows now
  always_comb begin
    head      = mem_r[rd_ptr_r];
    out_valid = (cnt_r != 2'd0);
    out_res   = sub_r ? head.r1 : head.r0;
    out_last  = !head.two || sub_r;
    room      = (cnt_r != 2'd2);
    beat      = out_valid && out_ready;
    pop       = beat && out_last;
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
    sub_nxt    = beat ? !out_last : sub_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      sub_r    <= sub_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
